@@ sv/hcs_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcs_pkg
// Shared types and constants for the HSL color shade pipeline.
// ----------------------------------------------------------------------------
package hcs_pkg;

    localparam int FIELD_W = 16;
    localparam int CHANNEL_BITS_DEF = 16;
    localparam int AMOUNT_FRAC_BITS_DEF = 12;

    // Hue, saturation and lightness carry FX fraction bits; 1.0 is 2^FX.
    localparam int FX = 24;
    localparam logic [FX:0] ONE = {1'b1, {FX{1'b0}}};
    localparam logic [FX:0] HALF_ONE = {2'b01, {(FX - 1){1'b0}}};

    localparam longint SHIFT_HI_K_L =
        (64'd97222 * (64'd1 << FX) + 64'd5000000) / 64'd10000000;
    localparam longint SHIFT_LO_K_L =
        (64'd33333 * (64'd1 << FX) + 64'd500000) / 64'd1000000;
    localparam longint SHIFT_LO_C_L =
        (64'd47222 * (64'd1 << FX) + 64'd500000) / 64'd1000000;
    localparam logic [FX-1:0] SHIFT_HI_K = FX'(SHIFT_HI_K_L);
    localparam logic [FX-1:0] SHIFT_LO_K = FX'(SHIFT_LO_K_L);
    localparam logic [FX-1:0] SHIFT_LO_C = FX'(SHIFT_LO_C_L);

    typedef enum logic [1:0] {
        ACT_SHADE      = 2'd0,
        ACT_SHADE_SHIFT = 2'd1,
        ACT_HUE_SHIFT  = 2'd2,
        ACT_SCALE_SAT  = 2'd3
    } act_t;

    typedef enum logic [1:0] {
        SEG_RISE = 2'd0,
        SEG_HIGH = 2'd1,
        SEG_FALL = 2'd2,
        SEG_LOW  = 2'd3
    } seg_t;

    typedef struct packed {
        act_t                       action;
        logic signed [FIELD_W-1:0]  amount;
        logic                       grey;
    } hcs_side_t;

    typedef struct packed {
        logic [FIELD_W-1:0] red;
        logic [FIELD_W-1:0] green;
        logic [FIELD_W-1:0] blue;
    } hcs_rgb_t;

endpackage

@@ sv/hcs_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcs_if
// Valid/ready channels for input pixels and shaded result pixels.
// ----------------------------------------------------------------------------
interface hcs_in_if
    import hcs_pkg::*;
    ();
    logic                       valid;
    logic                       ready;
    logic [1:0]                 action;
    logic [FIELD_W-1:0]         red_in;
    logic [FIELD_W-1:0]         green_in;
    logic [FIELD_W-1:0]         blue_in;
    logic signed [FIELD_W-1:0]  amount;

    modport source (output valid, action, red_in, green_in, blue_in, amount, input ready);
    modport sink (input valid, action, red_in, green_in, blue_in, amount, output ready);
endinterface

interface hcs_out_if
    import hcs_pkg::*;
    ();
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] red_out;
    logic [FIELD_W-1:0] green_out;
    logic [FIELD_W-1:0] blue_out;

    modport source (output valid, red_out, green_out, blue_out, input ready);
    modport sink (input valid, red_out, green_out, blue_out, output ready);
endinterface

@@ sv/hcs_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcs_div
// Pipelined restoring divider, one quotient bit per register stage.
// The upper DW bits of the numerator must be below the divisor.
// ----------------------------------------------------------------------------
module hcs_div
    import hcs_pkg::*;
#(
    parameter int DW = 19,
    parameter int QW = 25
)
(
    input  logic                clk,
    input  logic                en,
    input  logic [DW+QW-1:0]    num,
    input  logic [DW-1:0]       den,
    output logic [QW-1:0]       quo
);

    localparam int NW = DW + QW;

    logic [NW-1:0] acc_reg [QW];
    logic [DW-1:0] den_reg [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [NW-1:0] acc_in;
        logic [DW-1:0] den_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic [NW-1:0] acc_next;

        if (k == 0)
        begin : g_first
            assign acc_in = num;
            assign den_in = den;
        end
        else
        begin : g_rest
            assign acc_in = acc_reg[k-1];
            assign den_in = den_reg[k-1];
        end

        always_comb
        begin
            trial = acc_in[NW-1:QW-1];
            diff  = trial - {1'b0, den_in};
            if (trial >= {1'b0, den_in})
            begin
                acc_next = {diff[DW-1:0], acc_in[QW-2:0], 1'b1};
            end
            else
            begin
                acc_next = {trial[DW-1:0], acc_in[QW-2:0], 1'b0};
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                acc_reg[k] <= acc_next;
                den_reg[k] <= den_in;
            end
        end
    end

    assign quo = acc_reg[QW-1][QW-1:0];

endmodule

@@ sv/hsl_color_shade.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_color_shade
// Per-pixel HSL adjustment: shade, shade with hue shift, hue shift or
// saturation scale, converted from RGB and back to RGB.
// ----------------------------------------------------------------------------
// A pixel enters on the pixel channel as a transaction carrying an action,
// three color channels and a signed fixed-point amount. Each pixel gives
// exactly one transaction on the shaded channel, in the same order.
// The pipeline has 35 register stages. One pixel is taken every cycle
// while the skid register is empty. Depth is set by the two radix-2
// dividers (saturation and hue), which resolve one of their 25 quotient
// bits per stage. Lightness divides by a constant through a reciprocal
// product and a correction step, and then waits in a delay line beside
// the dividers. A skid register sits after the last stage, and
// pixel.ready comes from that register alone. When the receiver stalls,
// the pending result moves into the skid register, the whole pipeline
// freezes on the next cycle and pixel.ready drops until the skid register
// is emptied. Nothing is lost or repeated. Reset clears all valid bits,
// the skid register's among them; the block takes pixels in the first
// cycle after reset is released.
// ----------------------------------------------------------------------------
module hsl_color_shade
    import hcs_pkg::*;
#(
    parameter int CHANNEL_BITS = CHANNEL_BITS_DEF,
    parameter int AMOUNT_FRAC_BITS = AMOUNT_FRAC_BITS_DEF
)
(
    input logic     clk,
    input logic     rst_n,
    hcs_in_if.sink  pixel,
    hcs_out_if.source shaded
);

    localparam int CB  = CHANNEL_BITS;
    localparam int AF  = AMOUNT_FRAC_BITS;
    localparam int DW  = CB + 3;
    localparam int QW  = FX + 1;
    localparam int NW  = DW + QW;
    localparam int LW  = FX + 1;
    localparam int TW  = FX + 3;
    localparam int PW  = 2 * LW;
    localparam int PRW = LW + 1 + FIELD_W;
    localparam int CW  = LW + CB;
    localparam int NV  = QW + 10;
    localparam int LXW = CB + FX + 2;
    localparam int L_SH = CB + 2;
    localparam int LRW = FX + 2;
    localparam int LPW = CB + 1 + LRW;

    localparam logic [CB-1:0] CH_MAX = {CB{1'b1}};
    localparam logic [CB-1:0] GREY_MIN = CB'((2 ** CB - 1 + 9999) / 10000);
    localparam logic signed [FIELD_W-1:0] AMT_ONE = FIELD_W'(1 << AF);
    localparam logic [PRW-1:0] AMT_HALF = PRW'(1 << (AF - 1));
    localparam logic [TW-1:0] T_ONE   = TW'(ONE);
    localparam logic [TW-1:0] T_TWO   = TW'(ONE) << 1;
    localparam logic [TW-1:0] T_THREE = TW'(ONE) * TW'(3);
    localparam logic [TW-1:0] T_FOUR  = TW'(ONE) << 2;
    localparam logic [TW-1:0] T_SIX   = TW'(ONE) * TW'(6);
    localparam logic [LRW-1:0] L_RECIP =
        LRW'((longint'(1) << (FX + L_SH)) / (longint'(2) * ((longint'(1) << CB) - 1)));

    function automatic logic signed [PRW-1:0] mul_round(input logic signed [PRW-1:0] p);
        logic [PRW-1:0] mag;
        logic [PRW-1:0] r;
        mag = p[PRW-1] ? PRW'(-p) : PRW'(p);
        r = (mag + AMT_HALF) >> AF;
        mul_round = p[PRW-1] ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic [LW-1:0] clamp_unit(input logic signed [PRW-1:0] v);
        if (v[PRW-1])
        begin
            clamp_unit = '0;
        end
        else if (v > $signed(PRW'(ONE)))
        begin
            clamp_unit = ONE;
        end
        else
        begin
            clamp_unit = v[LW-1:0];
        end
    endfunction

    logic en;
    logic [NV-1:0] vld_reg;
    logic skid_valid_reg;
    hcs_rgb_t skid_reg;
    hcs_rgb_t final_reg;

    assign en = !skid_valid_reg;
    assign pixel.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NV-2:0], pixel.valid};
        end
    end

    // Input register.
    act_t act_s0_reg;
    logic [CB-1:0] r_s0_reg, g_s0_reg, b_s0_reg;
    logic signed [FIELD_W-1:0] amt_s0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            act_s0_reg <= act_t'(pixel.action);
            r_s0_reg   <= pixel.red_in[CB-1:0];
            g_s0_reg   <= pixel.green_in[CB-1:0];
            b_s0_reg   <= pixel.blue_in[CB-1:0];
            amt_s0_reg <= pixel.amount;
        end
    end

    // Channel spread, divider operands.
    logic [CB-1:0] mx, mn, delta, den_s;
    logic [CB:0] sum;
    logic signed [CB+3:0] rs, gs, bs, ds, hn;
    logic [NW-1:0] sat_num_next, hue_num_next;
    logic [LXW-1:0] l_num_next;
    logic [LPW-1:0] l_prod;
    logic [LW-1:0] l_est_next;
    logic [DW-1:0] sat_den_next, hue_den_next;

    always_comb
    begin
        mx = (r_s0_reg > g_s0_reg) ? r_s0_reg : g_s0_reg;
        if (b_s0_reg > mx)
        begin
            mx = b_s0_reg;
        end
        mn = (r_s0_reg < g_s0_reg) ? r_s0_reg : g_s0_reg;
        if (b_s0_reg < mn)
        begin
            mn = b_s0_reg;
        end
        sum   = {1'b0, mx} + {1'b0, mn};
        delta = mx - mn;
        if (sum <= {1'b0, CH_MAX})
        begin
            den_s = sum[CB-1:0];
        end
        else
        begin
            den_s = CB'({CH_MAX, 1'b0} - sum);
        end
        rs = $signed({4'b0, r_s0_reg});
        gs = $signed({4'b0, g_s0_reg});
        bs = $signed({4'b0, b_s0_reg});
        ds = $signed({4'b0, delta});
        if (r_s0_reg == mx)
        begin
            hn = gs - bs;
        end
        else if (g_s0_reg == mx)
        begin
            hn = (ds <<< 1) + bs - rs;
        end
        else
        begin
            hn = (ds <<< 2) + rs - gs;
        end
        if (hn < 0)
        begin
            hn = hn + (ds <<< 2) + (ds <<< 1);
        end
        sat_num_next = (NW'(delta) << FX) + NW'(den_s >> 1);
        sat_den_next = DW'(den_s);
        hue_num_next = (NW'(hn[CB+2:0]) << FX) + NW'(delta) + (NW'(delta) << 1);
        hue_den_next = (DW'(delta) << 2) + (DW'(delta) << 1);
        l_num_next   = (LXW'(sum) << FX) + LXW'(CH_MAX);
        l_prod       = LPW'(sum) * LPW'(L_RECIP);
        l_est_next   = LW'(l_prod >> L_SH);
    end

    logic [NW-1:0] sat_num_reg, hue_num_reg;
    logic [LXW-1:0] l_num_reg;
    logic [LW-1:0] l_est_reg;
    logic [DW-1:0] sat_den_reg, hue_den_reg;
    hcs_side_t side_s1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_num_reg <= sat_num_next;
            sat_den_reg <= sat_den_next;
            hue_num_reg <= hue_num_next;
            hue_den_reg <= hue_den_next;
            l_num_reg   <= l_num_next;
            l_est_reg   <= l_est_next;
            side_s1_reg <= '{action: act_s0_reg, amount: amt_s0_reg,
                             grey: (delta < GREY_MIN)};
        end
    end

    // The lightness estimate is at most one below the quotient.
    logic [LXW-1:0] l_mul2m, l_rem;
    logic [LW-1:0] l_fix;

    always_comb
    begin
        l_mul2m = (LXW'(l_est_reg) << (CB + 1)) - (LXW'(l_est_reg) << 1);
        l_rem   = l_num_reg - l_mul2m;
        l_fix   = (l_rem >= LXW'({CH_MAX, 1'b0})) ? (l_est_reg + LW'(1)) : l_est_reg;
    end

    logic [QW-1:0] sat_q, hue_q, l_q;

    hcs_div #(.DW(DW), .QW(QW)) u_div_sat (
        .clk(clk), .en(en), .num(sat_num_reg), .den(sat_den_reg), .quo(sat_q)
    );

    hcs_div #(.DW(DW), .QW(QW)) u_div_hue (
        .clk(clk), .en(en), .num(hue_num_reg), .den(hue_den_reg), .quo(hue_q)
    );

    hcs_side_t side_reg [QW];
    logic [LW-1:0] l_dly_reg [QW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0]  <= side_s1_reg;
            l_dly_reg[0] <= l_fix;
            for (int k = 1; k < QW; k++)
            begin
                side_reg[k]  <= side_reg[k-1];
                l_dly_reg[k] <= l_dly_reg[k-1];
            end
        end
    end

    assign l_q = l_dly_reg[QW-1];

    // Stage A: products with the amount.
    hcs_side_t side_d;
    logic [LW-1:0] sat0, mul_x;
    logic [FX-1:0] hue0, kc;
    logic hi;

    always_comb
    begin
        side_d = side_reg[QW-1];
        sat0  = side_d.grey ? '0 : sat_q;
        hue0  = side_d.grey ? '0 : hue_q[FX-1:0];
        mul_x = (side_d.action == ACT_SCALE_SAT) ? sat0 : l_q;
        hi    = (side_d.amount >= AMT_ONE);
        kc    = hi ? SHIFT_HI_K : SHIFT_LO_K;
    end

    logic signed [PRW-1:0] prod_a_reg, prod_k_reg;
    act_t act_a_reg;
    logic signed [FIELD_W-1:0] amt_a_reg;
    logic [LW-1:0] l_a_reg, s_a_reg;
    logic [FX-1:0] h_a_reg;
    logic hi_a_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_a_reg <= $signed({1'b0, mul_x}) * side_d.amount;
            prod_k_reg <= $signed({2'b0, kc}) * side_d.amount;
            act_a_reg  <= side_d.action;
            amt_a_reg  <= side_d.amount;
            l_a_reg    <= l_q;
            s_a_reg    <= sat0;
            h_a_reg    <= hue0;
            hi_a_reg   <= hi;
        end
    end

    // Stage B: rounding, clamping and the hue update.
    logic signed [PRW-1:0] rl, rk, dh;
    logic [LW-1:0] l_next, s_next;
    logic [FX-1:0] h_next, ash;

    always_comb
    begin
        rl  = mul_round(prod_a_reg);
        rk  = mul_round(prod_k_reg);
        dh  = hi_a_reg ? -rk : ($signed(PRW'(SHIFT_LO_C)) - rk);
        ash = FX'(amt_a_reg) << (FX - AF);
        l_next = l_a_reg;
        s_next = s_a_reg;
        h_next = h_a_reg;
        unique case (act_a_reg)
            ACT_SHADE:
            begin
                l_next = clamp_unit(rl);
            end
            ACT_SHADE_SHIFT:
            begin
                l_next = clamp_unit(rl);
                h_next = h_a_reg + dh[FX-1:0];
            end
            ACT_HUE_SHIFT:
            begin
                h_next = h_a_reg + ash;
            end
            ACT_SCALE_SAT:
            begin
                s_next = clamp_unit(rl);
            end
            default:
            begin
                l_next = l_a_reg;
            end
        endcase
    end

    logic [LW-1:0] l_b_reg, s_b_reg;
    logic [FX-1:0] h_b_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l_b_reg <= l_next;
            s_b_reg <= s_next;
            h_b_reg <= h_next;
        end
    end

    // Stage C: lightness times saturation, hue in sixths.
    logic [PW-1:0] ls_c_reg;
    logic [LW-1:0] l_c_reg, s_c_reg;
    logic [TW-1:0] h6_c_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ls_c_reg <= PW'(l_b_reg) * PW'(s_b_reg);
            l_c_reg  <= l_b_reg;
            s_c_reg  <= s_b_reg;
            h6_c_reg <= TW'(h_b_reg) * TW'(6);
        end
    end

    // Stage D: m1, m2 and the per-channel positions.
    logic [PW-1:0] ls_rnd;
    logic [LW:0] f, m2w, m1w;
    logic [TW-1:0] pos_next [3];

    always_comb
    begin
        ls_rnd = ls_c_reg + PW'(HALF_ONE);
        f = {1'b0, ls_rnd[FX+LW-1:FX]};
        if (l_c_reg <= HALF_ONE)
        begin
            m2w = {1'b0, l_c_reg} + f;
        end
        else
        begin
            m2w = {1'b0, l_c_reg} + {1'b0, s_c_reg} - f;
        end
        m1w = {l_c_reg, 1'b0} - m2w;
        pos_next[0] = h6_c_reg + T_TWO;
        if (pos_next[0] >= T_SIX)
        begin
            pos_next[0] = pos_next[0] - T_SIX;
        end
        pos_next[1] = h6_c_reg;
        pos_next[2] = (h6_c_reg >= T_TWO) ? (h6_c_reg - T_TWO) : (h6_c_reg + T_FOUR);
    end

    logic [LW-1:0] m1_d_reg, m2_d_reg;
    logic [TW-1:0] pos_d_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_d_reg <= m1w[LW-1:0];
            m2_d_reg <= m2w[LW-1:0];
            for (int c = 0; c < 3; c++)
            begin
                pos_d_reg[c] <= pos_next[c];
            end
        end
    end

    // Stage E: segment choice and ramp product.
    seg_t seg_next [3];
    logic [LW-1:0] fac [3];
    logic [LW-1:0] mdiff;

    always_comb
    begin
        mdiff = m2_d_reg - m1_d_reg;
        for (int c = 0; c < 3; c++)
        begin
            fac[c] = '0;
            if (pos_d_reg[c] < T_ONE)
            begin
                seg_next[c] = SEG_RISE;
                fac[c] = pos_d_reg[c][LW-1:0];
            end
            else if (pos_d_reg[c] < T_THREE)
            begin
                seg_next[c] = SEG_HIGH;
            end
            else if (pos_d_reg[c] < T_FOUR)
            begin
                seg_next[c] = SEG_FALL;
                fac[c] = LW'(T_FOUR - pos_d_reg[c]);
            end
            else
            begin
                seg_next[c] = SEG_LOW;
            end
        end
    end

    logic [PW-1:0] ramp_e_reg [3];
    seg_t seg_e_reg [3];
    logic [LW-1:0] m1_e_reg, m2_e_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m1_e_reg <= m1_d_reg;
            m2_e_reg <= m2_d_reg;
            for (int c = 0; c < 3; c++)
            begin
                ramp_e_reg[c] <= PW'(mdiff) * PW'(fac[c]);
                seg_e_reg[c]  <= seg_next[c];
            end
        end
    end

    // Stage F: channel value in lightness units.
    logic [PW-1:0] ramp_rnd [3];
    logic [LW-1:0] v_next [3];

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            ramp_rnd[c] = ramp_e_reg[c] + PW'(HALF_ONE);
            unique case (seg_e_reg[c])
                SEG_RISE, SEG_FALL: v_next[c] = m1_e_reg + ramp_rnd[c][FX+LW-1:FX];
                SEG_HIGH:           v_next[c] = m2_e_reg;
                SEG_LOW:            v_next[c] = m1_e_reg;
                default:            v_next[c] = m1_e_reg;
            endcase
        end
    end

    logic [LW-1:0] v_f_reg [3];
    logic [CW-1:0] pm_g_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                v_f_reg[c]  <= v_next[c];
                pm_g_reg[c] <= CW'(v_f_reg[c]) * CW'(CH_MAX);
            end
        end
    end

    // Stage H: scale to the channel range.
    logic [CW-1:0] pm_rnd [3];
    logic [CB:0] ch_raw [3];
    logic [CB-1:0] ch [3];
    hcs_rgb_t final_next;

    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            pm_rnd[c] = pm_g_reg[c] + CW'(HALF_ONE);
            ch_raw[c] = pm_rnd[c][CW-1:FX];
            ch[c] = (ch_raw[c] > {1'b0, CH_MAX}) ? CH_MAX : ch_raw[c][CB-1:0];
        end
        final_next.red   = FIELD_W'(ch[0]);
        final_next.green = FIELD_W'(ch[1]);
        final_next.blue  = FIELD_W'(ch[2]);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            final_reg <= final_next;
        end
    end

    // Output skid register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (shaded.ready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (vld_reg[NV-1] && !shaded.ready)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_valid_reg && vld_reg[NV-1] && !shaded.ready)
        begin
            skid_reg <= final_reg;
        end
    end

    assign shaded.valid     = skid_valid_reg || vld_reg[NV-1];
    assign shaded.red_out   = skid_valid_reg ? skid_reg.red : final_reg.red;
    assign shaded.green_out = skid_valid_reg ? skid_reg.green : final_reg.green;
    assign shaded.blue_out  = skid_valid_reg ? skid_reg.blue : final_reg.blue;

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HSL color shade pipeline: directed corner
// pixels, then random pixels, predicted in the bench and compared in order.
// ----------------------------------------------------------------------------
module tb;
    import hcs_pkg::*;

    localparam longint CMAX = 65535;
    localparam longint UNIT = longint'(1) << FX;
    localparam longint HALF = longint'(1) << (FX - 1);
    localparam longint AHALF = 2048;
    localparam int WATCHDOG = 20000;

    typedef struct {
        act_t act;
        logic [15:0] r, g, b;
        logic signed [15:0] amt;
    } pixel_t;

    typedef struct {
        logic [15:0] r, g, b;
    } color_t;

    logic clk;
    logic rst_n;
    hcs_in_if pix_if();
    hcs_out_if out_if();

    hsl_color_shade u_dut (
        .clk(clk), .rst_n(rst_n), .pixel(pix_if.sink), .shaded(out_if.source)
    );

    pixel_t pending[$];
    color_t expected_colors[$];
    int errors = 0;
    int idle_cycles = 0;
    bit stim_done = 0;
    int send_gap = 0;
    int recv_gap = 0;
    int hold_off = 0;
    bit hold_done = 0;
    bit in_fire = 0;
    int recv_count = 0;

    function automatic longint scale_amt(longint x, longint a);
        longint p;
        p = x * a;
        if (p >= 0)
            return (p + AHALF) >>> 12;
        return -((-p + AHALF) >>> 12);
    endfunction

    function automatic longint unit_clamp(longint v);
        if (v < 0)
            return 0;
        if (v > UNIT)
            return UNIT;
        return v;
    endfunction

    function automatic longint fmul(longint x, longint y);
        return (x * y + HALF) >>> FX;
    endfunction

    function automatic longint ramp(longint m1, longint m2, longint t);
        if (t < UNIT)
            return m1 + fmul(m2 - m1, t);
        if (t < 3 * UNIT)
            return m2;
        if (t < 4 * UNIT)
            return m1 + fmul(m2 - m1, 4 * UNIT - t);
        return m1;
    endfunction

    function automatic logic [15:0] to_chan(longint v);
        longint c;
        if (v < 0)
            v = 0;
        c = (v * CMAX + HALF) >>> FX;
        if (c > CMAX)
            c = CMAX;
        return c[15:0];
    endfunction

    function automatic color_t shade_pixel(pixel_t p);
        longint r, g, b, a, mx, mn, sum, delta, lq, sat, hue, num, dh;
        longint m1, m2, h6, tr, tb;
        color_t c;
        r = p.r; g = p.g; b = p.b; a = p.amt;
        sat = 0; hue = 0;
        mx = r > g ? r : g;
        if (b > mx) mx = b;
        mn = r < g ? r : g;
        if (b < mn) mn = b;
        sum = mx + mn;
        delta = mx - mn;
        lq = (sum * UNIT + CMAX) / (2 * CMAX);
        if (delta * 10000 >= CMAX && delta > 0) begin
            if (sum <= CMAX)
                sat = (delta * UNIT + sum / 2) / sum;
            else
                sat = (delta * UNIT + (2 * CMAX - sum) / 2) / (2 * CMAX - sum);
            if (r == mx)
                num = g - b;
            else if (g == mx)
                num = 2 * delta + b - r;
            else
                num = 4 * delta + r - g;
            if (num < 0)
                num += 6 * delta;
            hue = ((num << FX) + 3 * delta) / (6 * delta);
            hue &= UNIT - 1;
        end
        case (p.act)
            ACT_SHADE: lq = unit_clamp(scale_amt(lq, a));
            ACT_SHADE_SHIFT:
            begin
                lq = unit_clamp(scale_amt(lq, a));
                if (a >= 4096)
                    dh = -scale_amt(SHIFT_HI_K_L, a);
                else
                    dh = SHIFT_LO_C_L - scale_amt(SHIFT_LO_K_L, a);
                hue = (hue + dh) & (UNIT - 1);
            end
            ACT_HUE_SHIFT: hue = (hue + a * 4096) & (UNIT - 1);
            default: sat = unit_clamp(scale_amt(sat, a));
        endcase
        if (sat == 0) begin
            c.r = to_chan(lq); c.g = c.r; c.b = c.r;
        end else begin
            if (lq <= HALF)
                m2 = lq + fmul(lq, sat);
            else
                m2 = lq + sat - fmul(lq, sat);
            m1 = 2 * lq - m2;
            h6 = hue * 6;
            tr = h6 + 2 * UNIT;
            if (tr >= 6 * UNIT) tr -= 6 * UNIT;
            tb = h6 - 2 * UNIT;
            if (tb < 0) tb += 6 * UNIT;
            c.r = to_chan(ramp(m1, m2, tr));
            c.g = to_chan(ramp(m1, m2, h6));
            c.b = to_chan(ramp(m1, m2, tb));
        end
        return c;
    endfunction

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 55) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] rand_chan();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0) return 16'd0;
        if (k == 1) return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic pixel_t make_pixel(act_t act, int r, int g, int b, int amt);
        pixel_t p;
        p.act = act; p.r = 16'(r); p.g = 16'(g); p.b = 16'(b); p.amt = 16'(amt);
        return p;
    endfunction

    initial
    begin
        clk = 0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        act_t acts[4];
        pixel_t p;
        int k;
        acts[0] = ACT_SHADE; acts[1] = ACT_SHADE_SHIFT;
        acts[2] = ACT_HUE_SHIFT; acts[3] = ACT_SCALE_SAT;
        for (int i = 0; i < 4; i++)
        begin
            pending.push_back(make_pixel(acts[i], 65535, 0, 0, 32767));
            pending.push_back(make_pixel(acts[i], 0, 65535, 65535, -32768));
            pending.push_back(make_pixel(acts[i], 30000, 30003, 30001, 4096));
            pending.push_back(make_pixel(acts[i], 1000, 40000, 60000, 0));
            pending.push_back(make_pixel(acts[i], 50000, 20000, 60000, -1));
        end
        pending.push_back(make_pixel(ACT_SHADE, 65535, 65535, 65535, 8192));
        pending.push_back(make_pixel(ACT_SHADE_SHIFT, 60000, 10000, 5000, 4095));
        pending.push_back(make_pixel(ACT_HUE_SHIFT, 20000, 50000, 1, 20480));
        pending.push_back(make_pixel(ACT_SCALE_SAT, 20000, 10000, 12000, 12288));
        for (int i = 0; i < 1700; i++)
        begin
            p.act = act_t'($urandom_range(0, 3));
            k = $urandom_range(0, 9);
            p.r = rand_chan(); p.g = rand_chan(); p.b = rand_chan();
            if (k == 0)
            begin
                p.g = p.r; p.b = p.r + 16'($urandom_range(0, 6));
            end
            k = $urandom_range(0, 9);
            if (k < 6)
                p.amt = 16'($urandom_range(0, 12288));
            else if (k < 8)
                p.amt = 16'($urandom_range(0, 65535));
            else
                p.amt = 16'(-int'($urandom_range(0, 8192)));
            pending.push_back(p);
        end
        stim_done = 1;
    end

    initial
    begin
        rst_n = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
    end

    always @(posedge clk)
    begin
        in_fire <= pix_if.valid && pix_if.ready;
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_if.valid <= 0;
            pix_if.action <= 0;
            pix_if.red_in <= 0;
            pix_if.green_in <= 0;
            pix_if.blue_in <= 0;
            pix_if.amount <= 0;
        end
        else if (!pix_if.valid || in_fire)
        begin
            if (send_gap > 0 || pending.size() == 0)
            begin
                pix_if.valid <= 0;
                if (send_gap > 0)
                    send_gap <= send_gap - 1;
            end
            else
            begin
                pix_if.valid <= 1;
                pix_if.action <= pending[0].act;
                pix_if.red_in <= pending[0].r;
                pix_if.green_in <= pending[0].g;
                pix_if.blue_in <= pending[0].b;
                pix_if.amount <= pending[0].amt;
                expected_colors.push_back(shade_pixel(pending[0]));
                void'(pending.pop_front());
                send_gap <= pick_gap();
            end
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_if.ready <= 0;
        else if (hold_off > 0)
        begin
            out_if.ready <= 0;
            hold_off <= hold_off - 1;
        end
        else if (recv_count >= 60 && !hold_done)
        begin
            out_if.ready <= 0;
            hold_off <= 200;
            hold_done <= 1;
        end
        else if (recv_gap > 0)
        begin
            out_if.ready <= 0;
            recv_gap <= recv_gap - 1;
        end
        else
        begin
            out_if.ready <= 1;
            recv_gap <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_if.valid && out_if.ready)
        begin
            recv_count <= recv_count + 1;
            if (expected_colors.size() == 0)
            begin
                $error("result transaction with no pixel pending");
                errors = errors + 1;
            end
            else
            begin
                if (out_if.red_out !== expected_colors[0].r)
                begin
                    $error("red_out expected %0d got %0d", expected_colors[0].r, out_if.red_out);
                    errors = errors + 1;
                end
                if (out_if.green_out !== expected_colors[0].g)
                begin
                    $error("green_out expected %0d got %0d", expected_colors[0].g,
                        out_if.green_out);
                    errors = errors + 1;
                end
                if (out_if.blue_out !== expected_colors[0].b)
                begin
                    $error("blue_out expected %0d got %0d", expected_colors[0].b,
                        out_if.blue_out);
                    errors = errors + 1;
                end
                void'(expected_colors.pop_front());
            end
        end
    end

    always @(posedge clk)
    begin
        if ((pix_if.valid && pix_if.ready) || (out_if.valid && out_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        wait (stim_done);
        wait (rst_n);
        @(posedge clk);
        while (pending.size() != 0 || pix_if.valid || expected_colors.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0 && expected_colors.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end
endmodule
